/* hw/rtl/serial_slave_register_map_unit_assert.svh */
// assertion macros used by the checker file
`ifndef SERIAL_SLAVE_REGISTER_MAP_UNIT_ASSERT_SVH
`define SERIAL_SLAVE_REGISTER_MAP_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SSRM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("ssrm check failed");

// next-cycle implication, checked while out of reset
`define SSRM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("ssrm check failed");

`endif

/* hw/rtl/ssrm_pkg.sv */
// package: constants, codes and the stage struct of the serial slave register map
`timescale 1ns / 1ps

package ssrm_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int FIFO_W     = 16;
	localparam int MAP_DEPTH  = 256;
	localparam int MAP_AW     = 8;
	localparam int FILL_W     = 5;

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	// actions
	localparam logic [2:0] ACT_BUS       = 3'd0;
	localparam logic [2:0] ACT_POP       = 3'd1;
	localparam logic [2:0] ACT_MAP_READ  = 3'd2;
	localparam logic [2:0] ACT_MAP_WRITE = 3'd3;
	localparam logic [2:0] ACT_SET_PTR   = 3'd4;
	localparam logic [2:0] ACT_CLR_PTR   = 3'd5;
	localparam logic [2:0] ACT_REPLY     = 3'd6;

	// port modes
	localparam logic [1:0] MODE_SPI_M = 2'd0;
	localparam logic [1:0] MODE_SPI_S = 2'd1;
	localparam logic [1:0] MODE_I2C_S = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_EN    = 1'd1;

	// source of data_out
	localparam logic [1:0] DSEL_NONE = 2'd0;
	localparam logic [1:0] DSEL_FIFO = 2'd1;
	localparam logic [1:0] DSEL_MAP  = 2'd2;

	localparam logic [7:0] UNSET_ADDR = 8'hFF;

	typedef struct packed {
		logic              tx_load;
		logic              tx_from_map;
		logic [7:0]        tx_host;
		logic              notify;
		logic [1:0]        dsel;
		logic              map_hit;
		logic [FILL_W-1:0] fill;
	} ssrm_s1_t;

endpackage

/* hw/rtl/serial_slave_register_map_unit.sv */
// top level of the serial slave register map unit
//
//  channel | direction | handshake         | payload
//  s       | in        | s_tvalid/s_tready | s_tdata, s_tuser
//  m       | out       | m_tvalid/m_tready | m_tdata
//  cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// one item per cycle while m_tready does not stall the output
// the ram read registers at accept, the output register loads when that stage advances
// all accesses issue at accept, so later items see earlier writes without forwarding
// a load and a store at the pointer in one item forward the received byte
// reset clears the map through per-entry valid bits at once, no clearing pass
// with m_tready low the block holds two items, then drops s_tready
`timescale 1ns / 1ps

module serial_slave_register_map_unit import ssrm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// flag_stop, flag_start, flag_read, flag_full, bus_byte, host_addr, host_byte
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action, flag_data
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tx_load, tx_byte, notify, data_out, addr_out, fill_count
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic               accept;
	ssrm_s1_t           ctl;
	logic               map_we, fifo_we;
	logic [MAP_AW-1:0]  map_waddr, map_raddr;
	logic [7:0]         map_wdata, map_rdata;
	logic [FIFO_AW-1:0] fifo_waddr, fifo_raddr;
	logic [FIFO_W-1:0]  fifo_wdata, fifo_rdata;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	ssrm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_data    (s_tdata),
		.in_user    (s_tuser),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.map_we     (map_we),
		.map_waddr  (map_waddr),
		.map_wdata  (map_wdata),
		.map_raddr  (map_raddr),
		.fifo_we    (fifo_we),
		.fifo_waddr (fifo_waddr),
		.fifo_wdata (fifo_wdata),
		.fifo_raddr (fifo_raddr),
		.ctl        (ctl)
	);

	ssrm_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (accept),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	ssrm_ram #(.WIDTH(FIFO_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.re    (accept),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	ssrm_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.ctl        (ctl),
		.map_rdata  (map_rdata),
		.fifo_rdata (fifo_rdata),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

/* hw/rtl/ssrm_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module ssrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/ssrm_ctrl.sv */
// item decode, pointer and fifo bookkeeping, memory access issue
`timescale 1ns / 1ps

module ssrm_ctrl import ssrm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [IN_USER_W-1:0]  in_user,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  map_we,
	output logic [MAP_AW-1:0]     map_waddr,
	output logic [7:0]            map_wdata,
	output logic [MAP_AW-1:0]     map_raddr,
	output logic                  fifo_we,
	output logic [FIFO_AW-1:0]    fifo_waddr,
	output logic [FIFO_W-1:0]     fifo_wdata,
	output logic [FIFO_AW-1:0]    fifo_raddr,
	output ssrm_s1_t              ctl
);

	logic [1:0]           mode_q;
	logic                 map_en_q;
	logic [7:0]           ptr_q;
	logic                 ptr_vld_q;
	logic [FIFO_AW-1:0]   head_q;
	logic [FIFO_AW-1:0]   tail_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MAP_DEPTH-1:0] map_vld_q;

	logic [2:0] action;
	logic       f_data, f_stop, f_start, f_read, f_full;
	logic [7:0] bus_byte, host_addr, host_byte;

	logic             store, send, push, pop;
	logic [7:0]       ptr_d;
	logic             ptr_vld_d;
	logic [CNT_W-1:0] cnt_d;
	logic [7:0]       store_addr;

	assign action    = in_user[2:0];
	assign f_data    = in_user[3];
	assign f_stop    = in_data[0];
	assign f_start   = in_data[1];
	assign f_read    = in_data[2];
	assign f_full    = in_data[3];
	assign bus_byte  = in_data[11:4];
	assign host_addr = in_data[19:12];
	assign host_byte = in_data[27:20];

	assign store_addr = ptr_vld_q ? ptr_q : UNSET_ADDR;

	always_comb begin
		store     = 1'b0;
		send      = 1'b0;
		ptr_d     = ptr_q;
		ptr_vld_d = ptr_vld_q;
		ctl       = '0;
		ctl.dsel  = DSEL_NONE;
		case (action)
			ACT_BUS: begin
				case (mode_q)
					MODE_SPI_M: begin
						store = f_read | f_full;
					end
					MODE_SPI_S: begin
						if (!ptr_vld_q) begin
							ptr_d     = bus_byte;
							ptr_vld_d = 1'b1;
						end else begin
							store = 1'b1;
							send  = 1'b1;
						end
					end
					MODE_I2C_S: begin
						if (!f_stop && f_start) begin
							if (f_read) begin
								send = 1'b1;
							end else if (f_data) begin
								if (!ptr_vld_q) begin
									ptr_d     = bus_byte;
									ptr_vld_d = 1'b1;
								end else begin
									store = 1'b1;
								end
							end else begin
								ptr_vld_d = 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
				// pointer only moves when it was already set
				if ((send || store) && ptr_vld_q) begin
					ptr_d = ptr_q + 8'd1;
				end
				ctl.notify      = store;
				ctl.tx_load     = send & ptr_vld_q & map_en_q;
				// a load together with a store at the pointer sends the byte just stored
				ctl.tx_from_map = !store;
				ctl.tx_host     = bus_byte;
			end
			ACT_POP: begin
				if (cnt_q != '0) begin
					ctl.dsel = DSEL_FIFO;
				end
			end
			ACT_MAP_READ: begin
				ctl.dsel = DSEL_MAP;
			end
			ACT_SET_PTR: begin
				ptr_d     = host_addr;
				ptr_vld_d = 1'b1;
			end
			ACT_CLR_PTR: begin
				ptr_vld_d = 1'b0;
			end
			ACT_REPLY: begin
				ctl.tx_load = !map_en_q && (mode_q == MODE_SPI_S || mode_q == MODE_I2C_S);
				ctl.tx_host = host_byte;
			end
			default: begin
			end
		endcase
		// map entries never written read as zero
		ctl.map_hit = map_vld_q[map_raddr];
		ctl.fill    = FILL_W'(cnt_d);
	end

	assign push = (action == ACT_BUS) && store && !map_en_q && (cnt_q < CNT_W'(FIFO_DEPTH));
	assign pop  = (action == ACT_POP) && (cnt_q != '0);

	always_comb begin
		cnt_d = cnt_q;
		if (push) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign map_raddr = (action == ACT_MAP_READ) ? host_addr : ptr_q;
	assign map_we    = accept && ((action == ACT_MAP_WRITE) ||
		((action == ACT_BUS) && store && map_en_q));
	assign map_waddr = (action == ACT_MAP_WRITE) ? host_addr : store_addr;
	assign map_wdata = (action == ACT_MAP_WRITE) ? host_byte : bus_byte;

	assign fifo_we    = accept && push;
	assign fifo_waddr = tail_q;
	assign fifo_wdata = {store_addr, bus_byte};
	assign fifo_raddr = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_I2C_S;
			map_en_q  <= 1'b0;
			ptr_q     <= '0;
			ptr_vld_q <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			map_vld_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PORT_MODE: mode_q   <= cfg_wdata;
					CFG_MAP_EN:    map_en_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				ptr_q     <= ptr_d;
				ptr_vld_q <= ptr_vld_d;
				cnt_q     <= cnt_d;
				if (push) begin
					tail_q <= (tail_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + FIFO_AW'(1);
				end
				if (pop) begin
					head_q <= (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_q + FIFO_AW'(1);
				end
			end
			if (map_we) begin
				map_vld_q[map_waddr] <= 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/ssrm_out.sv */
// read-data stage and output register with handshake
`timescale 1ns / 1ps

module ssrm_out import ssrm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  ssrm_s1_t              ctl,
	input  logic [7:0]            map_rdata,
	input  logic [FIFO_W-1:0]     fifo_rdata,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic                  vld_s1;
	ssrm_s1_t              ctl_s1;
	logic                  out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  advance;
	logic [7:0]            map_byte, tx_byte, data_out, addr_out;

	// ram outputs only change on accept, so a stalled stage keeps its read data
	assign advance  = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	assign map_byte = ctl_s1.map_hit ? map_rdata : 8'd0;

	always_comb begin
		tx_byte = 8'd0;
		if (ctl_s1.tx_load) begin
			tx_byte = ctl_s1.tx_from_map ? map_byte : ctl_s1.tx_host;
		end
		data_out = 8'd0;
		addr_out = 8'd0;
		case (ctl_s1.dsel)
			DSEL_FIFO: begin
				data_out = fifo_rdata[7:0];
				addr_out = fifo_rdata[15:8];
			end
			DSEL_MAP: begin
				data_out = map_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
		end
		if (advance) begin
			out_data_q <= {1'b0, ctl_s1.fill, addr_out, data_out, ctl_s1.notify,
				tx_byte, ctl_s1.tx_load};
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

endmodule

/* hw/rtl/ssrm_checker.sv */
// port-level checker for the serial slave register map unit, with its bind
`timescale 1ns / 1ps
`include "serial_slave_register_map_unit_assert.svh"

module ssrm_checker import ssrm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// with the output register empty the block always takes an item
	`SSRM_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

	// no transmit byte without a load
	`SSRM_ASSERT_IMPL(a_tx_byte_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0)

	// fifo fill never passes its depth
	`SSRM_ASSERT_IMPL(a_fill_bound, clk, arst_n, m_tvalid, int'(m_tdata[30:26]) <= FIFO_DEPTH)

	// a stalled result holds
	`SSRM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind serial_slave_register_map_unit ssrm_checker u_ssrm_checker (.*);
